### rtl/rgb2yc_pkg.sv
// Package for the BT.2020 RGB to narrow-range YCbCr converter.
// Holds widths, conversion weights, depth codes and the sideband type.
// No dependencies; every other file of the block imports it.
package rgb2yc_pkg;

  // Payload and datapath widths.
  localparam int PIX_W  = 16;  // one color component or one result component
  localparam int CFG_W  = 5;   // configuration register width
  localparam int SUM_W  = 30;  // weighted sums, at most 10000 * 65535
  localparam int DEN_W  = 31;  // divisors, at most 18814 * 65535
  localparam int REM_W  = 31;  // divider partial remainder, always below the divisor
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // BT.2020 luma weights scaled by 10000, and the chroma divisors scaled alike.
  localparam logic [13:0] W_R    = 14'd2627;
  localparam logic [13:0] W_G    = 14'd6780;
  localparam logic [13:0] W_B    = 14'd593;
  localparam logic [13:0] W_SUM  = 14'd10000;
  localparam logic [14:0] CB_DIV = 15'd18814;
  localparam logic [14:0] CR_DIV = 15'd14746;

  // Narrow-range scales at 8 bits; deeper outputs shift them up.
  localparam logic [7:0] LUMA_SCALE   = 8'd219;
  localparam logic [7:0] CHROMA_SCALE = 8'd224;

  // Supported output depths.
  localparam logic [CFG_W-1:0] OUT_DEPTH_8  = 5'd8;
  localparam logic [CFG_W-1:0] OUT_DEPTH_10 = 5'd10;
  localparam logic [CFG_W-1:0] OUT_DEPTH_12 = 5'd12;
  localparam logic [CFG_W-1:0] OUT_DEPTH_16 = 5'd16;

  // Input depth limits and the reset depth of both registers.
  localparam logic [CFG_W-1:0] RGB_DEPTH_MIN   = 5'd1;
  localparam logic [CFG_W-1:0] RGB_DEPTH_MAX   = 5'd16;
  localparam logic [CFG_W-1:0] CFG_RESET_DEPTH = 5'd8;

  // Luma black level and chroma mid level per output depth.
  localparam logic [PIX_W-1:0] LUMA_OFS_8    = 16'd16;
  localparam logic [PIX_W-1:0] LUMA_OFS_10   = 16'd64;
  localparam logic [PIX_W-1:0] LUMA_OFS_12   = 16'd256;
  localparam logic [PIX_W-1:0] LUMA_OFS_16   = 16'd4096;
  localparam logic [PIX_W-1:0] CHROMA_MID_8  = 16'd128;
  localparam logic [PIX_W-1:0] CHROMA_MID_10 = 16'd512;
  localparam logic [PIX_W-1:0] CHROMA_MID_12 = 16'd2048;
  localparam logic [PIX_W-1:0] CHROMA_MID_16 = 16'd32768;

  // Register index, taken from bit 2 of the byte address.
  typedef enum logic {
    REG_RGB_DEPTH = 1'b0,
    REG_YCC_DEPTH = 1'b1
  } reg_idx_e;

  // Per-pixel flags that travel beside the dividers.
  typedef struct packed {
    logic y_sat;
    logic cb_neg;
    logic cb_sat;
    logic cr_neg;
    logic cr_sat;
  } side_t;

endpackage

### rtl/rgb2yc_if.sv
// Valid/ready stream interfaces of the converter: RGB words in, YCbCr words out.
// Depends on rgb2yc_pkg for the component width.
interface rgb2yc_rgb_if import rgb2yc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgb2yc_ycc_if import rgb2yc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] luma;
  logic [PIX_W-1:0] chroma_blue;
  logic [PIX_W-1:0] chroma_red;

  modport source (output valid, output luma, output chroma_blue, output chroma_red,
                  input ready);
  modport sink   (input valid, input luma, input chroma_blue, input chroma_red,
                  output ready);
endinterface

### rtl/rgb2yc_divider.sv
// Pipelined restoring divider: one quotient bit per register stage, FRAC_BITS stages.
// Computes floor(num * 2^FRAC_BITS / den) for num < den. Depends on rgb2yc_pkg.
module rgb2yc_divider import rgb2yc_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [REM_W-1:0]     num_i,
  input  logic [DEN_W-1:0]     den_i,
  output logic [FRAC_BITS-1:0] quo_o
);

  logic [REM_W-1:0]     rem_q [FRAC_BITS];
  logic [FRAC_BITS-1:0] quo_q [FRAC_BITS];

  logic [REM_W-1:0]     rem_d [FRAC_BITS];
  logic [FRAC_BITS-1:0] quo_d [FRAC_BITS];

  // Each stage doubles the remainder and subtracts the divisor when it fits.
  always_comb begin
    logic [REM_W:0]       trial;
    logic [REM_W:0]       diff;
    logic                 ge;
    logic [FRAC_BITS-1:0] quo_in;
    for (int k = 0; k < FRAC_BITS; k++) begin
      if (k == 0) begin
        trial  = {num_i, 1'b0};
        quo_in = '0;
      end else begin
        trial  = {rem_q[k-1], 1'b0};
        quo_in = quo_q[k-1];
      end
      diff     = trial - {1'b0, den_i};
      ge       = (trial >= {1'b0, den_i});
      rem_d[k] = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      quo_d[k] = {quo_in[FRAC_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < FRAC_BITS; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
      end
    end
  end

  assign quo_o = quo_q[FRAC_BITS-1];

endmodule

### rtl/rgb_to_ycbcr_bt2020.sv
// Top level of the BT.2020 RGB to narrow-range YCbCr converter.
// Depends on rgb2yc_pkg, rgb2yc_if and rgb2yc_divider.

// The converter takes one RGB word per clock while pix_i.ready is high and
// returns one YCbCr word per clock, in order, while ycc_o.ready is high. The
// pipeline is built around the three restoring dividers, which resolve one
// quotient bit per pipeline stage; four stages before them register the
// input, form the weighted sums, take the chroma differences and check
// saturation, and two stages after them scale and offset the results.
// Components are normalized by 2^rgb_bit_depth - 1 (a depth of 0 acts as 1,
// above 16 as 16). Y is clipped to [0,1] and Cb, Cr to [-0.5,0.5], then
// quantized to narrow range at ycbcr_bit_depth with truncation toward zero; an
// output depth other than 8, 10, 12 or 16 gives all-zero words. The whole
// pipeline advances together and holds while the skid register is full; that
// register, behind the output register, keeps pix_i.ready a registered signal,
// so a new word is taken while a finished one still waits. The two depth
// registers sit at byte addresses 0 and 4 of the APB port and must only be
// written while no word is in flight.
module rgb_to_ycbcr_bt2020 import rgb2yc_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rgb2yc_rgb_if.sink        pix_i,
  rgb2yc_ycc_if.source      ycc_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int PY_W = FRAC_BITS + 8;  // luma times 219, luma at most 1.0
  localparam int PC_W = FRAC_BITS + 7;  // chroma magnitude times 224, at most 0.5

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] rgb_depth_q;
  logic [CFG_W-1:0] ycc_depth_q;
  logic             cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rgb_depth_q <= CFG_RESET_DEPTH;
      ycc_depth_q <= CFG_RESET_DEPTH;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[2]))
        REG_RGB_DEPTH: rgb_depth_q <= pwdata[CFG_W-1:0];
        REG_YCC_DEPTH: ycc_depth_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[2]))
      REG_RGB_DEPTH: prdata = {{(APB_DW-CFG_W){1'b0}}, rgb_depth_q};
      REG_YCC_DEPTH: prdata = {{(APB_DW-CFG_W){1'b0}}, ycc_depth_q};
      default:       prdata = '0;
    endcase
  end

  // The divisors follow the input depth. They are registered once per cycle;
  // the user must change configuration only while the pipeline is empty (the
  // block does not enforce it); they then settle before any word reads them.
  logic [CFG_W-1:0] rgb_depth_eff;
  logic [PIX_W-1:0] max_val;
  logic [DEN_W-1:0] den_y_q, den_cb_q, den_cr_q;

  always_comb begin
    rgb_depth_eff = rgb_depth_q;
    if (rgb_depth_q < RGB_DEPTH_MIN) begin
      rgb_depth_eff = RGB_DEPTH_MIN;
    end else if (rgb_depth_q > RGB_DEPTH_MAX) begin
      rgb_depth_eff = RGB_DEPTH_MAX;
    end
    max_val = PIX_W'((17'd1 << rgb_depth_eff) - 17'd1);
  end

  always_ff @(posedge clk_i) begin
    den_y_q  <= DEN_W'(W_SUM)  * DEN_W'(max_val);
    den_cb_q <= DEN_W'(CB_DIV) * DEN_W'(max_val);
    den_cr_q <= DEN_W'(CR_DIV) * DEN_W'(max_val);
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. Every stage through stage M moves on the same enable,
  // which drops only while the skid register is occupied.
  // ---------------------------------------------------------------------------
  logic                 pipe_en;
  logic                 skid_vld_q;
  logic                 out_vld_q;
  logic                 s0_vld_q, s1_vld_q, s2_vld_q, s3_vld_q, m_vld_q;
  logic [FRAC_BITS-1:0] dv_vld_q;

  assign pipe_en     = !skid_vld_q;
  assign pix_i.ready = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      dv_vld_q <= '0;
      m_vld_q  <= 1'b0;
    end else if (pipe_en) begin
      s0_vld_q <= pix_i.valid;
      s1_vld_q <= s0_vld_q;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      dv_vld_q <= {dv_vld_q[FRAC_BITS-2:0], s3_vld_q};
      m_vld_q  <= dv_vld_q[FRAC_BITS-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: input register. Stage 1: weighted sums.
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] s0_r_q, s0_g_q, s0_b_q;
  logic [SUM_W-1:0] s1_ysum_q, s1_bw_q, s1_rw_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s0_r_q    <= pix_i.red;
      s0_g_q    <= pix_i.green;
      s0_b_q    <= pix_i.blue;
      s1_ysum_q <= SUM_W'(W_R) * SUM_W'(s0_r_q) + SUM_W'(W_G) * SUM_W'(s0_g_q)
                 + SUM_W'(W_B) * SUM_W'(s0_b_q);
      s1_bw_q   <= SUM_W'(W_SUM) * SUM_W'(s0_b_q);
      s1_rw_q   <= SUM_W'(W_SUM) * SUM_W'(s0_r_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: chroma differences as sign and magnitude, luma saturation.
  // Stage 3: chroma saturation; a saturated lane feeds zero to its divider.
  // ---------------------------------------------------------------------------
  logic             s2_ysat_q, s2_cbneg_q, s2_crneg_q;
  logic [SUM_W-1:0] s2_ysum_q, s2_cbmag_q, s2_crmag_q;
  side_t            s3_side_q;
  logic [REM_W-1:0] s3_ynum_q, s3_cbnum_q, s3_crnum_q;
  logic             cb_sat, cr_sat;

  assign cb_sat = ({s2_cbmag_q, 1'b0} >= den_cb_q);
  assign cr_sat = ({s2_crmag_q, 1'b0} >= den_cr_q);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s2_ysum_q  <= s1_ysum_q;
      s2_ysat_q  <= (DEN_W'(s1_ysum_q) >= den_y_q);
      s2_cbneg_q <= (s1_bw_q < s1_ysum_q);
      s2_cbmag_q <= (s1_bw_q < s1_ysum_q) ? s1_ysum_q - s1_bw_q : s1_bw_q - s1_ysum_q;
      s2_crneg_q <= (s1_rw_q < s1_ysum_q);
      s2_crmag_q <= (s1_rw_q < s1_ysum_q) ? s1_ysum_q - s1_rw_q : s1_rw_q - s1_ysum_q;

      s3_side_q.y_sat  <= s2_ysat_q;
      s3_side_q.cb_neg <= s2_cbneg_q;
      s3_side_q.cb_sat <= cb_sat;
      s3_side_q.cr_neg <= s2_crneg_q;
      s3_side_q.cr_sat <= cr_sat;
      s3_ynum_q  <= s2_ysat_q ? '0 : REM_W'(s2_ysum_q);
      s3_cbnum_q <= cb_sat    ? '0 : REM_W'(s2_cbmag_q);
      s3_crnum_q <= cr_sat    ? '0 : REM_W'(s2_crmag_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Dividers: FRAC_BITS stages, flags shift alongside.
  // ---------------------------------------------------------------------------
  logic [FRAC_BITS-1:0] quo_y, quo_cb, quo_cr;
  side_t                dv_side_q [FRAC_BITS];

  rgb2yc_divider #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .num_i (s3_ynum_q),
    .den_i (den_y_q),
    .quo_o (quo_y)
  );

  rgb2yc_divider #(.FRAC_BITS(FRAC_BITS)) u_div_cb (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .num_i (s3_cbnum_q),
    .den_i (den_cb_q),
    .quo_o (quo_cb)
  );

  rgb2yc_divider #(.FRAC_BITS(FRAC_BITS)) u_div_cr (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .num_i (s3_crnum_q),
    .den_i (den_cr_q),
    .quo_o (quo_cr)
  );

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dv_side_q[0] <= s3_side_q;
      for (int k = 1; k < FRAC_BITS; k++) begin
        dv_side_q[k] <= dv_side_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage M: apply saturation and scale by the 8-bit narrow-range factors.
  // The depth-dependent power of two is folded into the final shift.
  // ---------------------------------------------------------------------------
  side_t             dv_side;
  logic [FRAC_BITS:0]   y_fx;
  logic [FRAC_BITS-1:0] cb_fx, cr_fx;
  logic [PY_W-1:0]   m_py_q;
  logic [PC_W-1:0]   m_pcb_q, m_pcr_q;
  logic              m_cbneg_q, m_crneg_q;

  assign dv_side = dv_side_q[FRAC_BITS-1];
  assign y_fx    = dv_side.y_sat  ? {1'b1, {FRAC_BITS{1'b0}}} : {1'b0, quo_y};
  assign cb_fx   = dv_side.cb_sat ? {1'b1, {(FRAC_BITS-1){1'b0}}} : quo_cb;
  assign cr_fx   = dv_side.cr_sat ? {1'b1, {(FRAC_BITS-1){1'b0}}} : quo_cr;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      m_py_q    <= PY_W'(y_fx)  * PY_W'(LUMA_SCALE);
      m_pcb_q   <= PC_W'(cb_fx) * PC_W'(CHROMA_SCALE);
      m_pcr_q   <= PC_W'(cr_fx) * PC_W'(CHROMA_SCALE);
      m_cbneg_q <= dv_side.cb_neg;
      m_crneg_q <= dv_side.cr_neg;
    end
  end

  // ---------------------------------------------------------------------------
  // Final quantization: drop FRAC_BITS - s fraction bits (s = depth - 8), then
  // add the black level or the chroma mid level. An unsupported depth leaves
  // every term at zero, so the word comes out all zero.
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] fin_luma, fin_cb, fin_cr;

  always_comb begin
    logic [PY_W-1:0]  py_sh;
    logic [PC_W-1:0]  pcb_sh, pcr_sh;
    logic [PIX_W-1:0] l_ofs, c_mid;
    case (ycc_depth_q)
      OUT_DEPTH_8: begin
        py_sh  = m_py_q  >> FRAC_BITS;
        pcb_sh = m_pcb_q >> FRAC_BITS;
        pcr_sh = m_pcr_q >> FRAC_BITS;
        l_ofs  = LUMA_OFS_8;
        c_mid  = CHROMA_MID_8;
      end
      OUT_DEPTH_10: begin
        py_sh  = m_py_q  >> (FRAC_BITS - 2);
        pcb_sh = m_pcb_q >> (FRAC_BITS - 2);
        pcr_sh = m_pcr_q >> (FRAC_BITS - 2);
        l_ofs  = LUMA_OFS_10;
        c_mid  = CHROMA_MID_10;
      end
      OUT_DEPTH_12: begin
        py_sh  = m_py_q  >> (FRAC_BITS - 4);
        pcb_sh = m_pcb_q >> (FRAC_BITS - 4);
        pcr_sh = m_pcr_q >> (FRAC_BITS - 4);
        l_ofs  = LUMA_OFS_12;
        c_mid  = CHROMA_MID_12;
      end
      OUT_DEPTH_16: begin
        py_sh  = m_py_q  >> (FRAC_BITS - 8);
        pcb_sh = m_pcb_q >> (FRAC_BITS - 8);
        pcr_sh = m_pcr_q >> (FRAC_BITS - 8);
        l_ofs  = LUMA_OFS_16;
        c_mid  = CHROMA_MID_16;
      end
      default: begin
        py_sh  = '0;
        pcb_sh = '0;
        pcr_sh = '0;
        l_ofs  = '0;
        c_mid  = '0;
      end
    endcase
    fin_luma = py_sh[PIX_W-1:0] + l_ofs;
    fin_cb   = m_cbneg_q ? c_mid - pcb_sh[PIX_W-1:0] : c_mid + pcb_sh[PIX_W-1:0];
    fin_cr   = m_crneg_q ? c_mid - pcr_sh[PIX_W-1:0] : c_mid + pcr_sh[PIX_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Output register and skid register. A finished word goes to the output
  // register when it is free or being taken, otherwise into the skid register,
  // which then freezes the pipeline until the output drains.
  // ---------------------------------------------------------------------------
  logic             out_take;
  logic             new_word;
  logic [PIX_W-1:0] out_luma_q, out_cb_q, out_cr_q;
  logic [PIX_W-1:0] skid_luma_q, skid_cb_q, skid_cr_q;

  assign out_take = !out_vld_q || ycc_o.ready;
  assign new_word = pipe_en && m_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_take) begin
      out_vld_q  <= skid_vld_q || new_word;
      skid_vld_q <= 1'b0;
    end else if (new_word) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      if (skid_vld_q) begin
        out_luma_q <= skid_luma_q;
        out_cb_q   <= skid_cb_q;
        out_cr_q   <= skid_cr_q;
      end else begin
        out_luma_q <= fin_luma;
        out_cb_q   <= fin_cb;
        out_cr_q   <= fin_cr;
      end
    end else if (new_word) begin
      skid_luma_q <= fin_luma;
      skid_cb_q   <= fin_cb;
      skid_cr_q   <= fin_cr;
    end
  end

  assign ycc_o.valid       = out_vld_q;
  assign ycc_o.luma        = out_luma_q;
  assign ycc_o.chroma_blue = out_cb_q;
  assign ycc_o.chroma_red  = out_cr_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // An accepted word occupies the first stage on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready) |=> s0_vld_q)
    else $error("accepted word did not enter the pipeline");

  // While frozen, no valid bit in the divider or scaling stages may move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> ($stable(dv_vld_q) && $stable(m_vld_q)))
    else $error("pipeline moved while stalled");

  // The skid register fills only when the output register was held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && !ycc_o.ready))
    else $error("skid register filled while output was free");

  // A word in the skid register always has an older word ahead of it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register holds a word with an empty output register");

endmodule
